[src/sia_pkg.sv]
// Package for the signed integer ALU / multiply / divide unit.
// Holds the data width, operation codes, channel payloads and the per-cell struct. No dependencies.
package sia_pkg;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned ModeWidth = 3;
	localparam int unsigned IdxWidth  = $clog2(DataWidth);

	typedef enum logic [ModeWidth-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	typedef logic [DataWidth-1:0] word_t;

	// Input transaction
	typedef struct packed {
		logic [ModeWidth-1:0] mode;
		word_t                operand_a;
		word_t                operand_b;
	} req_t;

	// Output transaction
	typedef struct packed {
		word_t result_value;
	} res_t;

	// Everything one division cell hands to the next
	typedef struct packed {
		logic [ModeWidth-1:0] mode;
		word_t                a;
		word_t                b;
		word_t                mb;
		word_t                rem;
		word_t                quo;
		logic                 neg;
	} cell_t;
endpackage

[src/sia_if.sv]
// Valid/ready channel interface carrying a payload of one packed type.
// Depends on nothing; payload type is given at instantiation.
interface sia_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/sia_cell.sv]
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on sia_pkg.
module sia_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [sia_pkg::IdxWidth-1:0]  bit_idx,
	input  logic                          valid_d,
	input  sia_pkg::cell_t                d,
	output logic                          valid_q,
	output sia_pkg::cell_t                q
);
	logic [sia_pkg::DataWidth:0] shifted;
	logic [sia_pkg::DataWidth:0] diff;
	sia_pkg::cell_t              nxt;

	// Shift in the next dividend bit and try the subtract; quo holds the
	// untouched dividend bits below bit_idx and quotient bits above it
	always_comb begin
		nxt     = d;
		shifted = {d.rem, d.quo[bit_idx]};
		diff    = shifted - {1'b0, d.mb};
		if (!diff[sia_pkg::DataWidth]) begin
			nxt.rem          = diff[sia_pkg::DataWidth-1:0];
			nxt.quo[bit_idx] = 1'b1;
		end else begin
			nxt.rem          = shifted[sia_pkg::DataWidth-1:0];
			nxt.quo[bit_idx] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

[src/signed_integer_alu_mul_div.sv]
// Signed ALU / multiply / divide unit, one transaction per cycle while the output is not held.
// Pipeline: entry register, 32 divider cells, signed-quotient stage s1,
// multiply-back stage s2, output register; every op takes the same path.
// Throughput: one transaction per cycle; the whole chain stalls only when the output holds.
// Reset: arst_n clears all valid flags; payload registers are not reset.
module signed_integer_alu_mul_div (
	input logic clk,
	input logic arst_n,
	sia_if.sink   in_ch,
	sia_if.source out_ch
);
	localparam int unsigned W = sia_pkg::DataWidth;

	logic           en;
	logic [W:0]     vld;
	sia_pkg::cell_t chain [0:W];
	sia_pkg::word_t mag_a, mag_b;
	logic           entry_v_q;
	sia_pkg::cell_t entry_q;

	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Entry: magnitudes and sign of the quotient
	assign mag_a = in_ch.data.operand_a[W-1] ? -in_ch.data.operand_a : in_ch.data.operand_a;
	assign mag_b = in_ch.data.operand_b[W-1] ? -in_ch.data.operand_b : in_ch.data.operand_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_v_q <= 1'b0;
		end else if (en) begin
			entry_v_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q.mode <= in_ch.data.mode;
			entry_q.a    <= in_ch.data.operand_a;
			entry_q.b    <= in_ch.data.operand_b;
			entry_q.mb   <= mag_b;
			entry_q.rem  <= '0;
			entry_q.quo  <= mag_a;
			entry_q.neg  <= in_ch.data.operand_a[W-1] ^ in_ch.data.operand_b[W-1];
		end
	end

	assign vld[0]   = entry_v_q;
	assign chain[0] = entry_q;

	// Divider chain; quo holds |a| on entry and is replaced bit by bit
	// with the quotient, most significant bit first
	genvar g;
	generate
		for (g = 0; g < W; g++) begin : g_cell
			sia_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.bit_idx (sia_pkg::IdxWidth'(W-1-g)),
				.valid_d (vld[g]),
				.d       (chain[g]),
				.valid_q (vld[g+1]),
				.q       (chain[g+1])
			);
		end
	endgenerate

	// Stage s1: signed quotient
	logic                          v_s1;
	logic [sia_pkg::ModeWidth-1:0] mode_s1;
	sia_pkg::word_t                a_s1, b_s1, q_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vld[W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= chain[W].mode;
			a_s1    <= chain[W].a;
			b_s1    <= chain[W].b;
			q_s1    <= chain[W].neg ? -chain[W].quo : chain[W].quo;
		end
	end

	// Stage s2: one shared multiplier for multiply and remainder
	logic                          v_s2;
	logic [sia_pkg::ModeWidth-1:0] mode_s2;
	sia_pkg::word_t                a_s2, b_s2, q_s2, p_s2;
	sia_pkg::word_t                mul_x;
	assign mul_x = (mode_s1 == sia_pkg::OP_MUL) ? a_s1 : q_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			q_s2    <= q_s1;
			p_s2    <= W'(mul_x * b_s1);
		end
	end

	// Output register
	sia_pkg::word_t res;
	always_comb begin
		unique case (mode_s2)
			sia_pkg::OP_ADD: res = a_s2 + b_s2;
			sia_pkg::OP_SUB: res = a_s2 - b_s2;
			sia_pkg::OP_MUL: res = p_s2;
			sia_pkg::OP_DIV: res = q_s2;
			sia_pkg::OP_REM: res = a_s2 - p_s2;
			default:         res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (en) out_ch.valid <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) out_ch.data.result_value <= res;
	end
endmodule
